// ===== rtl/core/rfd_pkg.sv =====
// rfd_pkg: shared types, constants and register codes of the rotor failure detector
// used by every module under rtl/core; depends on nothing else
package rfd_pkg;

  // default sizes handed to the top-level parameters
  localparam int RATE_WIDTH_DEF  = 16;
  localparam int DT_SAT_BITS_DEF = 32;

  // fixed field widths
  localparam int STAMP_W  = 64;
  localparam int HEIGHT_W = 18;
  localparam int CNT_W    = 8;
  localparam int LIM_W    = 20;
  localparam int LEVEL_W  = 10;
  localparam int ROTOR_W  = 3;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 20;
  localparam int USEC_W   = 20;

  // microseconds per second, scales the rate difference before compare
  localparam logic [USEC_W-1:0] US_PER_S = 20'd1000000;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_DECIMATION     = 3'd0,
    REG_BREACH_RUN     = 3'd1,
    REG_ACCEL_LIMIT    = 3'd2,
    REG_CLASSIFY_LIMIT = 3'd3,
    REG_DISARM_LEVEL   = 3'd4
  } rfd_reg_e;

  // rotor codes
  typedef enum logic [ROTOR_W-1:0] {
    ROTOR_NONE = 3'd0,
    ROTOR_1    = 3'd1,
    ROTOR_2    = 3'd2,
    ROTOR_3    = 3'd3,
    ROTOR_4    = 3'd4
  } rotor_e;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0]   DECIMATION_RST     = 8'd1;
  localparam logic [CNT_W-1:0]   BREACH_RUN_RST     = 8'd1;
  localparam logic [LIM_W-1:0]   ACCEL_LIMIT_RST    = 20'd25600;
  localparam logic [LIM_W-1:0]   CLASSIFY_LIMIT_RST = 20'd4096;
  localparam logic [LEVEL_W-1:0] DISARM_LEVEL_RST   = 10'd10;

  typedef struct packed {
    logic [CNT_W-1:0]   decimation;
    logic [CNT_W-1:0]   breach_run;
    logic [LIM_W-1:0]   accel_limit;
    logic [LIM_W-1:0]   classify_limit;
    logic [LEVEL_W-1:0] disarm_level;
  } rfd_cfg_t;

  // control flags of a sample between front stage and evaluation stage
  typedef struct packed {
    logic used;      // sample passed decimation
    logic evaluate;  // sample kept and a previous sample existed
    logic zero;      // interval was zero
  } rfd_ctl_t;

  // one result beat
  typedef struct packed {
    logic               sample_used;
    logic               breach;
    logic               zero_interval;
    logic               failure_latched;
    logic [ROTOR_W-1:0] failed_rotor;
    logic               disarm_request;
  } rfd_res_t;

endpackage

// ===== rtl/core/rfd_cfg.sv =====
// rfd_cfg: configuration register file of the rotor failure detector
// depends on rfd_pkg
module rfd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rfd_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [rfd_pkg::DATA_W-1:0]   cfg_data_i,
  output rfd_pkg::rfd_cfg_t            cfg_o
);

  rfd_pkg::rfd_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (rfd_pkg::rfd_reg_e'(cfg_index_i))
        rfd_pkg::REG_DECIMATION:     cfg_d.decimation     = cfg_data_i[rfd_pkg::CNT_W-1:0];
        rfd_pkg::REG_BREACH_RUN:     cfg_d.breach_run     = cfg_data_i[rfd_pkg::CNT_W-1:0];
        rfd_pkg::REG_ACCEL_LIMIT:    cfg_d.accel_limit    = cfg_data_i[rfd_pkg::LIM_W-1:0];
        rfd_pkg::REG_CLASSIFY_LIMIT: cfg_d.classify_limit = cfg_data_i[rfd_pkg::LIM_W-1:0];
        rfd_pkg::REG_DISARM_LEVEL:   cfg_d.disarm_level   = cfg_data_i[rfd_pkg::LEVEL_W-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decimation     <= rfd_pkg::DECIMATION_RST;
      cfg_q.breach_run     <= rfd_pkg::BREACH_RUN_RST;
      cfg_q.accel_limit    <= rfd_pkg::ACCEL_LIMIT_RST;
      cfg_q.classify_limit <= rfd_pkg::CLASSIFY_LIMIT_RST;
      cfg_q.disarm_level   <= rfd_pkg::DISARM_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/rfd_front.sv =====
// rfd_front: input stage of the rotor failure detector: decimation, previous
// sample store, rate differences and saturated interval; depends on rfd_pkg
module rfd_front #(
  parameter int RATE_WIDTH  = rfd_pkg::RATE_WIDTH_DEF,
  parameter int DT_SAT_BITS = rfd_pkg::DT_SAT_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  rfd_pkg::rfd_cfg_t                      cfg_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [rfd_pkg::STAMP_W-1:0]            stamp_us_i,
  input  logic signed [RATE_WIDTH-1:0]           rate_x_i,
  input  logic signed [RATE_WIDTH-1:0]           rate_y_i,
  input  logic signed [RATE_WIDTH-1:0]           rate_z_i,
  input  logic signed [rfd_pkg::HEIGHT_W-1:0]    height_cm_i,
  input  logic                                   eval_ready_i,
  output logic                                   s1_valid_o,
  output rfd_pkg::rfd_ctl_t                      ctl_o,
  output logic [2:0][RATE_WIDTH:0]               mag_o,
  output logic [1:0]                             neg_o,
  output logic [DT_SAT_BITS-1:0]                 dt_o,
  output logic signed [rfd_pkg::HEIGHT_W-1:0]    height_o
);

  localparam int MagW = RATE_WIDTH + 1;

  logic                                in_accept;
  logic                                keep;
  logic [rfd_pkg::CNT_W-1:0]           decim_count_q, decim_count_d;
  logic [RATE_WIDTH-1:0]               prev_rate_q [3];
  logic [rfd_pkg::STAMP_W-1:0]         prev_stamp_q;
  logic                                primed_q;
  logic [RATE_WIDTH-1:0]               rate_in [3];
  logic signed [MagW-1:0]              diff [3];
  logic [2:0][MagW-1:0]                mag;
  logic [rfd_pkg::STAMP_W-1:0]         dt_full;
  logic [DT_SAT_BITS-1:0]              dt_sat;

  logic                                s1_valid_q, s1_valid_d;
  rfd_pkg::rfd_ctl_t                   ctl_q, ctl_d;
  logic [2:0][MagW-1:0]                mag_q;
  logic [1:0]                          neg_q;
  logic [DT_SAT_BITS-1:0]              dt_q;
  logic signed [rfd_pkg::HEIGHT_W-1:0] height_q;

  assign in_ready_o = !s1_valid_q || eval_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // a decimation of zero behaves as one
  assign keep = ({1'b0, decim_count_q} + (rfd_pkg::CNT_W + 1)'(1))
                >= {1'b0, cfg_i.decimation};
  assign decim_count_d = keep ? '0 : decim_count_q + rfd_pkg::CNT_W'(1);

  assign rate_in[0] = rate_x_i;
  assign rate_in[1] = rate_y_i;
  assign rate_in[2] = rate_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({rate_in[i][RATE_WIDTH-1], rate_in[i]})
              - $signed({prev_rate_q[i][RATE_WIDTH-1], prev_rate_q[i]});
      mag[i]  = diff[i][MagW-1] ? MagW'(-diff[i]) : MagW'(diff[i]);
    end
  end

  // wrapped difference, clamped to the saturation width
  assign dt_full = stamp_us_i - prev_stamp_q;
  assign dt_sat  = (dt_full[rfd_pkg::STAMP_W-1:DT_SAT_BITS] != '0) ? '1
                                                                    : dt_full[DT_SAT_BITS-1:0];

  always_comb begin
    ctl_d.used     = keep;
    ctl_d.evaluate = keep && primed_q;
    ctl_d.zero     = (dt_sat == '0);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (eval_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  // sample history, updated when a kept beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_count_q <= '0;
      primed_q      <= 1'b0;
      prev_stamp_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_rate_q[i] <= '0;
      end
      s1_valid_q    <= 1'b0;
      ctl_q         <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_accept) begin
        decim_count_q <= decim_count_d;
        ctl_q         <= ctl_d;
        if (keep) begin
          primed_q     <= 1'b1;
          prev_stamp_q <= stamp_us_i;
          for (int i = 0; i < 3; i++) begin
            prev_rate_q[i] <= rate_in[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mag_q    <= mag;
      neg_q    <= {diff[1][MagW-1], diff[0][MagW-1]};
      dt_q     <= dt_sat;
      height_q <= height_cm_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign ctl_o      = ctl_q;
  assign mag_o      = mag_q;
  assign neg_o      = neg_q;
  assign dt_o       = dt_q;
  assign height_o   = height_q;

endmodule

// ===== rtl/core/rfd_eval.sv =====
// rfd_eval: evaluation stage of the rotor failure detector: scaled compares,
// breach run, failure latch, rotor naming and result register; depends on rfd_pkg
module rfd_eval #(
  parameter int RATE_WIDTH  = rfd_pkg::RATE_WIDTH_DEF,
  parameter int DT_SAT_BITS = rfd_pkg::DT_SAT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rfd_pkg::rfd_cfg_t                   cfg_i,
  input  logic                                s1_valid_i,
  input  rfd_pkg::rfd_ctl_t                   ctl_i,
  input  logic [2:0][RATE_WIDTH:0]            mag_i,
  input  logic [1:0]                          neg_i,
  input  logic [DT_SAT_BITS-1:0]              dt_i,
  input  logic signed [rfd_pkg::HEIGHT_W-1:0] height_i,
  output logic                                eval_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rfd_pkg::rfd_res_t                   res_o
);

  localparam int MagW  = RATE_WIDTH + 1;
  localparam int ProdW = MagW + rfd_pkg::USEC_W;
  localparam int LimW  = rfd_pkg::LIM_W + DT_SAT_BITS;
  localparam int CmpW  = (ProdW > LimW) ? ProdW : LimW;

  logic                        take;
  logic [ProdW-1:0]            prod [3];
  logic [LimW-1:0]             alim;
  logic [LimW-1:0]             clim;
  logic [2:0]                  over;
  logic [1:0]                  cls_gt;
  logic                        brk;
  logic                        run;
  logic                        sx_pos, sx_neg, sy_pos, sy_neg;
  rfd_pkg::rotor_e             rotor_cls;

  logic [rfd_pkg::CNT_W-1:0]   breach_count_q, breach_count_d;
  logic                        latched_q, latched_d;
  rfd_pkg::rotor_e             rotor_q, rotor_d;
  logic                        out_valid_q, out_valid_d;
  rfd_pkg::rfd_res_t           res_q, res_d;

  assign eval_ready_o = !out_valid_q || out_ready_i;
  assign take         = s1_valid_i && eval_ready_o;
  assign run          = ctl_i.evaluate && !ctl_i.zero;

  // two independent products against the interval, one per limit
  assign alim = LimW'(cfg_i.accel_limit) * LimW'(dt_i);
  assign clim = LimW'(cfg_i.classify_limit) * LimW'(dt_i);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = ProdW'(mag_i[i]) * ProdW'(rfd_pkg::US_PER_S);
      over[i] = CmpW'(prod[i]) > CmpW'(alim);
    end
    for (int i = 0; i < 2; i++) begin
      cls_gt[i] = CmpW'(prod[i]) > CmpW'(clim);
    end
  end

  assign brk    = run && (over != '0);
  assign sx_pos = !neg_i[0] && cls_gt[0];
  assign sx_neg = neg_i[0] && cls_gt[0];
  assign sy_pos = !neg_i[1] && cls_gt[1];
  assign sy_neg = neg_i[1] && cls_gt[1];

  always_comb begin
    if (sx_pos && sy_neg) begin
      rotor_cls = rfd_pkg::ROTOR_1;
    end else if (sx_pos && sy_pos) begin
      rotor_cls = rfd_pkg::ROTOR_4;
    end else if (sx_neg && sy_neg) begin
      rotor_cls = rfd_pkg::ROTOR_3;
    end else if (sx_neg && sy_pos) begin
      rotor_cls = rfd_pkg::ROTOR_2;
    end else begin
      rotor_cls = rfd_pkg::ROTOR_NONE;
    end
  end

  always_comb begin
    breach_count_d = breach_count_q;
    latched_d      = latched_q;
    rotor_d        = rotor_q;
    if (run) begin
      if (brk) begin
        if (breach_count_q != '1) begin
          breach_count_d = breach_count_q + rfd_pkg::CNT_W'(1);
        end
      end else begin
        breach_count_d = '0;
      end
      if ((breach_count_d >= cfg_i.breach_run) && !latched_q) begin
        latched_d = 1'b1;
        rotor_d   = rotor_cls;
      end
    end
  end

  always_comb begin
    res_d.sample_used     = ctl_i.used;
    res_d.breach          = brk;
    res_d.zero_interval   = ctl_i.evaluate && ctl_i.zero;
    res_d.failure_latched = latched_d;
    res_d.failed_rotor    = rotor_d;
    res_d.disarm_request  = latched_d && (rotor_d != rfd_pkg::ROTOR_NONE)
                            && (height_i < $signed(rfd_pkg::HEIGHT_W'(cfg_i.disarm_level)));
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      breach_count_q <= '0;
      latched_q      <= 1'b0;
      rotor_q        <= rfd_pkg::ROTOR_NONE;
      out_valid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        breach_count_q <= breach_count_d;
        latched_q      <= latched_d;
        rotor_q        <= rotor_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  // the failure latch is sticky
  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_q |=> latched_q)
    else $error("failure latch dropped");

  // rotor is frozen once the latch is set
  a_rotor_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_q |=> $stable(rotor_q))
    else $error("rotor changed after latch");

  // a named rotor only exists with the latch
  a_rotor_needs_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rotor_q != rfd_pkg::ROTOR_NONE) |-> latched_q)
    else $error("rotor named without latch");

  // a breach beat is always an evaluated sample with a real interval
  a_breach_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.breach) |-> (res_q.sample_used && !res_q.zero_interval))
    else $error("breach on unused or zero-interval sample");
`endif

endmodule

// ===== rtl/core/rotor_failure_detector.sv =====
// rotor_failure_detector: top level, gyro-based rotor failure detection
// depends on rfd_pkg, rfd_cfg, rfd_front and rfd_eval
//
//   channel   direction  handshake                   payload
//   in        sink       in_valid_i / in_ready_o     stamp_us_i, rate_x/y/z_i, height_cm_i
//   out       source     out_valid_o / out_ready_i   sample_used_o .. disarm_request_o
//   cfg       sink       cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// one beat in gives exactly one beat out, through the front and result registers
// one beat per cycle while out_ready_i is high: front stage (subtract, interval
// clamp) then evaluation stage (two interval products and the scaled compares)
// reset clears configuration to defaults, sample history, breach run and latch
// out_ready_i low holds the result register; the front stage still fills once
// cfg is always ready and must only be written while the block is idle
module rotor_failure_detector #(
  parameter int RATE_WIDTH  = rfd_pkg::RATE_WIDTH_DEF,
  parameter int DT_SAT_BITS = rfd_pkg::DT_SAT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample beats
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rfd_pkg::STAMP_W-1:0]          stamp_us_i,
  input  logic signed [RATE_WIDTH-1:0]         rate_x_i,
  input  logic signed [RATE_WIDTH-1:0]         rate_y_i,
  input  logic signed [RATE_WIDTH-1:0]         rate_z_i,
  input  logic signed [rfd_pkg::HEIGHT_W-1:0]  height_cm_i,
  // result beats
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 sample_used_o,
  output logic                                 breach_o,
  output logic                                 zero_interval_o,
  output logic                                 failure_latched_o,
  output logic [rfd_pkg::ROTOR_W-1:0]          failed_rotor_o,
  output logic                                 disarm_request_o,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rfd_pkg::IDX_W-1:0]            cfg_index_i,
  input  logic [rfd_pkg::DATA_W-1:0]           cfg_data_i
);

  rfd_pkg::rfd_cfg_t                   cfg;
  logic                                eval_ready;
  logic                                s1_valid;
  rfd_pkg::rfd_ctl_t                   s1_ctl;
  logic [2:0][RATE_WIDTH:0]            s1_mag;
  logic [1:0]                          s1_neg;
  logic [DT_SAT_BITS-1:0]              s1_dt;
  logic signed [rfd_pkg::HEIGHT_W-1:0] s1_height;
  rfd_pkg::rfd_res_t                   res;

  // configuration registers
  rfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // decimation, history and differences
  rfd_front #(
    .RATE_WIDTH  (RATE_WIDTH),
    .DT_SAT_BITS (DT_SAT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .stamp_us_i   (stamp_us_i),
    .rate_x_i     (rate_x_i),
    .rate_y_i     (rate_y_i),
    .rate_z_i     (rate_z_i),
    .height_cm_i  (height_cm_i),
    .eval_ready_i (eval_ready),
    .s1_valid_o   (s1_valid),
    .ctl_o        (s1_ctl),
    .mag_o        (s1_mag),
    .neg_o        (s1_neg),
    .dt_o         (s1_dt),
    .height_o     (s1_height)
  );

  // compares, breach run, latch, classification
  rfd_eval #(
    .RATE_WIDTH  (RATE_WIDTH),
    .DT_SAT_BITS (DT_SAT_BITS)
  ) u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .s1_valid_i   (s1_valid),
    .ctl_i        (s1_ctl),
    .mag_i        (s1_mag),
    .neg_i        (s1_neg),
    .dt_i         (s1_dt),
    .height_i     (s1_height),
    .eval_ready_o (eval_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  // result fields straight from the output register
  assign sample_used_o     = res.sample_used;
  assign breach_o          = res.breach;
  assign zero_interval_o   = res.zero_interval;
  assign failure_latched_o = res.failure_latched;
  assign failed_rotor_o    = res.failed_rotor;
  assign disarm_request_o  = res.disarm_request;

endmodule

// ===== tb/sv/rfd_tb_pkg.sv =====
// rfd_tb_pkg: sample beat type and scoreboard class for the rotor failure detector bench
// the scoreboard keeps its own copy of registers and detector state; depends on rfd_pkg
`timescale 1ns / 100ps
package rfd_tb_pkg;
  import rfd_pkg::*;

  localparam longint unsigned USEC_PER_SEC = 64'd1000000;
  localparam longint unsigned DT_CEIL      = (64'd1 << DT_SAT_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic [STAMP_W-1:0]               stamp_us;
    logic signed [RATE_WIDTH_DEF-1:0] rate_x;
    logic signed [RATE_WIDTH_DEF-1:0] rate_y;
    logic signed [RATE_WIDTH_DEF-1:0] rate_z;
    logic signed [HEIGHT_W-1:0]       height_cm;
  } gyro_beat_t;

  class rfd_scoreboard;
    // register copies
    bit [CNT_W-1:0]   decimation;
    bit [CNT_W-1:0]   breach_run;
    bit [LIM_W-1:0]   accel_limit;
    bit [LIM_W-1:0]   classify_limit;
    bit [LEVEL_W-1:0] disarm_level;
    // detector state
    bit [CNT_W-1:0]   decim_count;
    longint           prev_rate [3];
    longint unsigned  prev_stamp;
    bit               primed;
    bit [CNT_W-1:0]   breach_count;
    bit               latched;
    rotor_e           rotor;
    // flags still owed by the block, oldest first
    rfd_res_t         flags_due [$];
    int               beats_seen;
    int               errors;

    function new();
      decimation     = DECIMATION_RST;
      breach_run     = BREACH_RUN_RST;
      accel_limit    = ACCEL_LIMIT_RST;
      classify_limit = CLASSIFY_LIMIT_RST;
      disarm_level   = DISARM_LEVEL_RST;
      decim_count    = '0;
      prev_rate      = '{0, 0, 0};
      prev_stamp     = 0;
      primed         = 1'b0;
      breach_count   = '0;
      latched        = 1'b0;
      rotor          = ROTOR_NONE;
      beats_seen     = 0;
      errors         = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_DECIMATION:     decimation     = data[CNT_W-1:0];
        REG_BREACH_RUN:     breach_run     = data[CNT_W-1:0];
        REG_ACCEL_LIMIT:    accel_limit    = data[LIM_W-1:0];
        REG_CLASSIFY_LIMIT: classify_limit = data[LIM_W-1:0];
        REG_DISARM_LEVEL:   disarm_level   = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // +1 above the classify limit, -1 below its negative, else 0
    function int axis_sign(longint d, longint unsigned dt);
      longint unsigned lim;
      lim = classify_limit * dt;
      if (d > 0 && $unsigned(d) * USEC_PER_SEC > lim) return 1;
      if (d < 0 && $unsigned(-d) * USEC_PER_SEC > lim) return -1;
      return 0;
    endfunction

    function rfd_res_t predict_flags(gyro_beat_t b);
      rfd_res_t        r;
      longint          rate [3];
      longint          d [3];
      longint unsigned dt;
      longint unsigned lim;
      longint unsigned mag;
      bit              hit;
      int              sx;
      int              sy;
      r = '0;
      rate[0] = $signed(b.rate_x);
      rate[1] = $signed(b.rate_y);
      rate[2] = $signed(b.rate_z);
      if (int'(decim_count) + 1 >= int'(decimation)) begin
        decim_count   = '0;
        r.sample_used = 1'b1;
        if (primed) begin
          dt = b.stamp_us - prev_stamp;
          if (dt > DT_CEIL) dt = DT_CEIL;
          if (dt == 0) begin
            r.zero_interval = 1'b1;
          end else begin
            hit = 1'b0;
            lim = accel_limit * dt;
            for (int i = 0; i < 3; i++) begin
              d[i] = rate[i] - prev_rate[i];
              mag  = (d[i] < 0) ? $unsigned(-d[i]) : $unsigned(d[i]);
              if (mag * USEC_PER_SEC > lim) hit = 1'b1;
            end
            r.breach = hit;
            if (hit) begin
              if (breach_count != '1) breach_count = breach_count + 1'b1;
            end else begin
              breach_count = '0;
            end
            if (breach_count >= breach_run && !latched) begin
              sx      = axis_sign(d[0], dt);
              sy      = axis_sign(d[1], dt);
              latched = 1'b1;
              if (sx > 0 && sy < 0)      rotor = ROTOR_1;
              else if (sx > 0 && sy > 0) rotor = ROTOR_4;
              else if (sx < 0 && sy < 0) rotor = ROTOR_3;
              else if (sx < 0 && sy > 0) rotor = ROTOR_2;
              else                       rotor = ROTOR_NONE;
            end
          end
        end
        prev_rate  = rate;
        prev_stamp = b.stamp_us;
        primed     = 1'b1;
      end else begin
        decim_count = decim_count + 1'b1;
      end
      r.failure_latched = latched;
      r.failed_rotor    = rotor;
      r.disarm_request  = latched && rotor != ROTOR_NONE &&
                          longint'($signed(b.height_cm)) < longint'(disarm_level);
      return r;
    endfunction

    function void sample_accepted(gyro_beat_t b);
      flags_due.push_back(predict_flags(b));
    endfunction

    function void result_seen(rfd_res_t got);
      rfd_res_t want;
      beats_seen++;
      if (flags_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat %0d arrived with no sample pending", beats_seen);
        return;
      end
      want = flags_due.pop_front();
      if (got.sample_used !== want.sample_used || got.breach !== want.breach ||
          got.zero_interval !== want.zero_interval ||
          got.failure_latched !== want.failure_latched ||
          got.failed_rotor !== want.failed_rotor ||
          got.disarm_request !== want.disarm_request) begin
        errors++;
        if (errors <= 10) begin
          $display("beat %0d mismatch: exp used=%b brk=%b zero=%b lat=%b rotor=%0d dis=%b",
                   beats_seen, want.sample_used, want.breach, want.zero_interval,
                   want.failure_latched, want.failed_rotor, want.disarm_request);
          $display("               got used=%b brk=%b zero=%b lat=%b rotor=%0d dis=%b",
                   got.sample_used, got.breach, got.zero_interval,
                   got.failure_latched, got.failed_rotor, got.disarm_request);
        end
      end
    endfunction

    function int pending();
      return flags_due.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
// tb: top of the rotor failure detector regression, drives sample and register beats
// and checks every result beat through rfd_scoreboard; depends on rfd_pkg, rfd_tb_pkg, rtl
`timescale 1ns / 100ps
module tb;
  import rfd_pkg::*;
  import rfd_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  // two-stage pipe, a few spare cycles on top
  localparam int DRAIN_CYCLES = 8;
  // index past the register map, the block must ignore it
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint RATE_MAX = 2 ** (RATE_WIDTH_DEF - 1) - 1;
  localparam longint RATE_MIN = -(2 ** (RATE_WIDTH_DEF - 1));

  // kinds of gyro motion the stimulus is built from
  typedef enum int {MOVE_HOVER, MOVE_SPIN, MOVE_SKEW, MOVE_NOISE} move_e;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_ready_o;
  logic [STAMP_W-1:0]                 stamp_us_i = '0;
  logic signed [RATE_WIDTH_DEF-1:0]   rate_x_i = '0;
  logic signed [RATE_WIDTH_DEF-1:0]   rate_y_i = '0;
  logic signed [RATE_WIDTH_DEF-1:0]   rate_z_i = '0;
  logic signed [HEIGHT_W-1:0]         height_cm_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic                               sample_used_o;
  logic                               breach_o;
  logic                               zero_interval_o;
  logic                               failure_latched_o;
  logic [ROTOR_W-1:0]                 failed_rotor_o;
  logic                               disarm_request_o;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [IDX_W-1:0]                   cfg_index_i = REG_DECIMATION;
  logic [DATA_W-1:0]                  cfg_data_i = '0;

  rfd_scoreboard   sb;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              cycle_count = 0;
  // running gyro trajectory the random beats continue from
  longint unsigned stamp_now = 0;
  longint          rate_now [3] = '{0, 0, 0};

  rotor_failure_detector DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .stamp_us_i        (stamp_us_i),
    .rate_x_i          (rate_x_i),
    .rate_y_i          (rate_y_i),
    .rate_z_i          (rate_z_i),
    .height_cm_i       (height_cm_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sample_used_o     (sample_used_o),
    .breach_o          (breach_o),
    .zero_interval_o   (zero_interval_o),
    .failure_latched_o (failure_latched_o),
    .failed_rotor_o    (failed_rotor_o),
    .disarm_request_o  (disarm_request_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side stalls at random, decided at the falling edge
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= recv_idle_pct);
  end

  // every result beat goes to the scoreboard at the rising edge it is taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.result_seen({sample_used_o, breach_o, zero_interval_o, failure_latched_o,
                      failed_rotor_o, disarm_request_o});
    end
  end

  // hard stop if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("rotor_failure_detector regression: fail");
    $finish;
  end

  // one sample beat: random gaps before it, then hold until taken
  task automatic put_sample(gyro_beat_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    stamp_us_i  = b.stamp_us;
    rate_x_i    = b.rate_x;
    rate_y_i    = b.rate_y;
    rate_z_i    = b.rate_z;
    height_cm_i = b.height_cm;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.sample_accepted(b);
  endtask

  // drop valid, let every owed result come back, then give the pipe time to empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // register word with random junk above the field width
  function automatic logic [DATA_W-1:0] pad_word(int unsigned value, int width);
    logic [DATA_W-1:0] mask;
    mask = (DATA_W'(1) << width) - 1'b1;
    return (DATA_W'($urandom) & ~mask) | (DATA_W'(value) & mask);
  endfunction

  task automatic program_regs(int unsigned dec, int unsigned run, int unsigned accel,
                              int unsigned cls, int unsigned lvl);
    write_reg(REG_DECIMATION, pad_word(dec, CNT_W));
    write_reg(REG_BREACH_RUN, pad_word(run, CNT_W));
    write_reg(REG_ACCEL_LIMIT, pad_word(accel, LIM_W));
    write_reg(REG_CLASSIFY_LIMIT, pad_word(cls, LIM_W));
    write_reg(REG_DISARM_LEVEL, pad_word(lvl, LEVEL_W));
  endtask

  // keep the magnitude of a rate step, flip it if it would leave the rate range
  function automatic longint shift_rate(longint prev, longint delta);
    longint nxt;
    nxt = prev + delta;
    if (nxt > RATE_MAX || nxt < RATE_MIN) nxt = prev - delta;
    return nxt;
  endfunction

  function automatic gyro_beat_t pack_beat(longint h);
    gyro_beat_t b;
    b.stamp_us  = stamp_now;
    b.rate_x    = rate_now[0][RATE_WIDTH_DEF-1:0];
    b.rate_y    = rate_now[1][RATE_WIDTH_DEF-1:0];
    b.rate_z    = rate_now[2][RATE_WIDTH_DEF-1:0];
    b.height_cm = h[HEIGHT_W-1:0];
    return b;
  endfunction

  function automatic gyro_beat_t fixed_beat(longint unsigned stamp, longint x, longint y,
                                            longint z, longint h);
    stamp_now   = stamp;
    rate_now[0] = x;
    rate_now[1] = y;
    rate_now[2] = z;
    return pack_beat(h);
  endfunction

  // next beat of the trajectory; step sizes follow the current limits so that
  // hover stays under the breach threshold and spin clears both thresholds
  function automatic gyro_beat_t make_beat(move_e m);
    longint unsigned dt;
    longint unsigned thr_a;
    longint unsigned thr_c;
    longint          span;
    longint          big;
    longint          delta;
    longint          h;
    int              pick;
    dt    = $urandom_range(500, 8000);
    thr_a = sb.accel_limit * dt / USEC_PER_SEC;
    thr_c = sb.classify_limit * dt / USEC_PER_SEC;
    span  = (thr_a * 3 / 4 > RATE_MAX) ? RATE_MAX : thr_a * 3 / 4;
    big   = ((thr_a > thr_c) ? thr_a : thr_c) + 1 + $urandom_range(400);
    if (big > RATE_MAX) big = RATE_MAX;
    stamp_now = stamp_now + dt;
    for (int i = 0; i < 3; i++) begin
      delta = $urandom_range(2 * span);
      delta = delta - span;
      if (m == MOVE_SPIN && (i < 2 || $urandom_range(1) != 0)) begin
        delta = ($urandom_range(1) != 0) ? big : -big;
      end else if (m == MOVE_SKEW && i == 0) begin
        delta = ($urandom_range(1) != 0) ? big : -big;
      end
      rate_now[i] = shift_rate(rate_now[i], delta);
    end
    if (m == MOVE_NOISE) begin
      pick = $urandom_range(5);
      case (pick)
        0: stamp_now = stamp_now - dt;                          // repeated stamp
        1: stamp_now = stamp_now - dt - $urandom_range(1, 100000); // time runs back
        2: stamp_now = {$urandom, $urandom};                    // anywhere in 64 bits
        3: stamp_now = stamp_now + 64'h1_0000_0000 + $urandom;  // interval saturates
        4: begin
          for (int i = 0; i < 3; i++) rate_now[i] = ($urandom_range(1) != 0) ? RATE_MAX : RATE_MIN;
        end
        default: begin
          for (int i = 0; i < 3; i++) rate_now[i] = $signed(RATE_WIDTH_DEF'($urandom));
        end
      endcase
    end
    // mostly near the disarm level so both sides of the compare show up
    pick = $urandom_range(99);
    if (pick < 60) h = longint'($urandom_range(60)) - 30 + longint'(sb.disarm_level);
    else if (pick < 85) h = longint'($urandom_range(200000)) - 100000;
    else if (pick < 90) h = 100000;
    else if (pick < 95) h = -100000;
    else h = 0;
    return pack_beat(h);
  endfunction

  // hover stretches and spin bursts with some noise in between
  task automatic run_mix(int n, int hover_pct, int spin_pct);
    int k;
    int r;
    int len;
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      if (r < hover_pct) begin
        put_sample(make_beat(MOVE_HOVER));
        k++;
      end else if (r < hover_pct + spin_pct) begin
        len = $urandom_range(1, 6);
        repeat (len) put_sample(make_beat(MOVE_SPIN));
        k += len;
      end else begin
        put_sample(make_beat(MOVE_NOISE));
        k++;
      end
    end
  endtask

  initial begin
    bit          skew;
    int unsigned run;
    sb = new();

    // reset held, then released at a falling edge
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, reset register values first
    send_idle_pct = 33;
    recv_idle_pct = 47;
    put_sample(fixed_beat(1000, 0, 0, 0, 100000));            // priming sample
    put_sample(fixed_beat(1000, RATE_MAX, RATE_MIN, 1, -100000)); // zero interval
    put_sample(fixed_beat(5000, RATE_MAX, RATE_MIN, 1, 10));  // no change, height at level
    put_sample(fixed_beat(4000, RATE_MIN, RATE_MAX, -1, 9));  // time runs back, full swing
    put_sample(fixed_beat(4000 + (64'd1 << 40), RATE_MAX, RATE_MIN, 0, -1)); // long gap
    settle();

    // decimation zero acts as one; zero accel limit breaches on any change
    program_regs(0, 255, 0, 1048575, 1000);
    write_reg(REG_UNUSED, pad_word($urandom, DATA_W));
    put_sample(fixed_beat(4001, RATE_MAX, RATE_MIN, 0, 999));
    put_sample(fixed_beat(4002, RATE_MIN, RATE_MAX, 0, 1000));
    put_sample(fixed_beat(4003, RATE_MIN + 1, RATE_MAX, 0, 1001));
    put_sample(fixed_beat(4003, 0, 0, 0, 0));
    put_sample(fixed_beat(4004, 0, 0, 0, -5));
    settle();

    // every third sample kept, widest accel limit, zero classify limit
    program_regs(3, 255, 1048575, 0, 0);
    for (int k = 0; k < 9; k++) begin
      put_sample(fixed_beat(4005 + k, k * k, -k, 3 * (k % 2), k * 3 - 10));
    end
    settle();

    // random part, sender idles 33 / receiver 47
    program_regs(1, $urandom_range(30, 255), $urandom_range(20000, 60000),
                 $urandom_range(30000), $urandom_range(1000));
    run_mix(90, 60, 25);
    settle();

    // swapped idling, decimation on, any limits
    send_idle_pct = 47;
    recv_idle_pct = 33;
    program_regs($urandom_range(2, 4), $urandom_range(30, 254), $urandom_range(1048575),
                 $urandom_range(1048575), $urandom_range(1000));
    run_mix(90, 55, 25);
    settle();

    // no idling from here; widest decimation, no sample gets used
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_DECIMATION, pad_word(255, CNT_W));
    run_mix(100, 100, 0);
    settle();

    // latch a failure: breach run of zero or a short run, then a spin burst
    // long enough to reach it; skewed bursts step only the x rate past the thresholds
    run  = ($urandom_range(1) != 0) ? 0 : $urandom_range(2, 8);
    skew = ($urandom_range(5) == 0);
    program_regs(1, run, $urandom_range(10000, 60000), $urandom_range(20000),
                 $urandom_range(50, 1000));
    repeat (run + 1) put_sample(make_beat(skew ? MOVE_SKEW : MOVE_SPIN));
    run_mix(60, 60, 25);
    settle();

    // disarm level at both ends with the latch held
    write_reg(REG_DISARM_LEVEL, pad_word(0, LEVEL_W));
    run_mix(20, 60, 20);
    settle();
    write_reg(REG_DISARM_LEVEL, pad_word(1000, LEVEL_W));
    run_mix(20, 60, 20);
    settle();

    if (sb.pending() != 0) $display("%0d result beats never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rotor_failure_detector regression: pass");
    end else begin
      $display("rotor_failure_detector regression: fail");
    end
    $finish;
  end

endmodule
